>>> rtl/mch_pkg.sv
`timescale 1ns / 1ps

package mch_pkg;

    // Field widths of the request and result items.
    localparam int KEY_W      = 32;
    localparam int CAP_W      = 5;
    localparam int COUNT_W    = 32;
    localparam int WAY_OUT_W  = 4;

    // Default number of ways and reset value of the capacity register.
    localparam int              WAYS_DEFAULT  = 16;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

    // Saturation value of the hit counter.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Request tdata layout: access_key, restart, zero fill to whole bytes.
    localparam int S_KEY_LSB     = 0;
    localparam int S_RESTART_BIT = KEY_W;
    localparam int S_FIELDS_W    = KEY_W + 1;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    // Result tdata layout: hit, way_used, evicted_valid, evicted_key, hit_total.
    localparam int M_HIT_BIT     = 0;
    localparam int M_WAY_LSB     = 1;
    localparam int M_EVV_BIT     = M_WAY_LSB + WAY_OUT_W;
    localparam int M_EVK_LSB     = M_EVV_BIT + 1;
    localparam int M_TOTAL_LSB   = M_EVK_LSB + KEY_W;
    localparam int M_FIELDS_W    = M_TOTAL_LSB + COUNT_W;
    localparam int M_TDATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

>>> rtl/mru_cache_hit_counter.sv
`timescale 1ns / 1ps
// A request passes through the input register and then the result register; it
// waits in the input register while the result channel stalls.
// Throughput: one request per cycle while the result channel does not stall; the
// tag compare over all ways and the state update are combinational in between.
// Reset (aresetn low, synchronous): cache empty, counter zero, capacity 16,
// both channel registers empty.

module mru_cache_hit_counter #(
    parameter int WAYS = mch_pkg::WAYS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // cfg_data: capacity[4:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mch_pkg::CAP_W-1:0]     cfg_data,
    // s_tdata: access_key[31:0], restart[32], zero[39:33]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mch_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: hit[0], way_used[4:1], evicted_valid[5], evicted_key[37:6],
    //          hit_total[69:38], zero[71:70]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mch_pkg::M_TDATA_W-1:0] m_tdata
);
    import mch_pkg::*;

    localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW = $clog2(WAYS + 1);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    // Configuration register, always ready.
    logic [CAP_W-1:0] cap_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAPACITY_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    // Input register.
    logic             in_valid_reg;
    logic [KEY_W-1:0] in_key_reg;
    logic             in_restart_reg;
    logic             out_free;
    logic             proc;

    assign out_free = !m_tvalid || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg     <= s_tdata[S_KEY_LSB +: KEY_W];
            in_restart_reg <= s_tdata[S_RESTART_BIT];
        end
    end

    // Cache control state.
    logic [FW-1:0]      fill_reg,   fill_next;
    logic [IW-1:0]      recent_reg, recent_next;
    logic [COUNT_W-1:0] count_reg,  count_next;

    logic [FW-1:0]      fill_eff;
    logic [IW-1:0]      recent_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [CW-1:0]      cap_eff;
    logic [CW-1:0]      cap_ext;

    logic               hit;
    logic [IW-1:0]      hit_way;
    logic               victim_valid;
    logic [KEY_W-1:0]   victim_key;
    logic               miss_wr;
    logic [IW-1:0]      way;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;

    mch_tag_store #(
        .WAYS (WAYS),
        .IW   (IW)
    ) u_tag_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lookup_key   (in_key_reg),
        .flush        (in_restart_reg),
        .upd_en       (proc),
        .wr_en        (miss_wr),
        .wr_way       (way),
        .victim_way   (recent_eff),
        .hit          (hit),
        .hit_way      (hit_way),
        .victim_valid (victim_valid),
        .victim_key   (victim_key)
    );

    // Restart empties the cache before the lookup.
    assign fill_eff   = in_restart_reg ? '0 : fill_reg;
    assign recent_eff = in_restart_reg ? '0 : recent_reg;
    assign count_eff  = in_restart_reg ? '0 : count_reg;

    // Capacity clamped to the range one to WAYS.
    assign cap_ext = CW'(cap_reg);
    always_comb begin
        cap_eff = cap_ext;
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (cap_ext > CW'(WAYS)) begin
            cap_eff = CW'(WAYS);
        end
    end

    // Hit, fill or replace decision.
    always_comb begin
        miss_wr     = 1'b0;
        way         = hit_way;
        evicted     = 1'b0;
        evicted_key = '0;
        fill_next   = fill_eff;
        count_next  = count_eff;
        if (hit) begin
            if (count_eff != COUNT_MAX) begin
                count_next = count_eff + COUNT_W'(1);
            end
        end else begin
            miss_wr = 1'b1;
            if (CW'(fill_eff) < cap_eff) begin
                way       = IW'(fill_eff);
                fill_next = fill_eff + FW'(1);
            end else begin
                way = recent_eff;
                if (victim_valid) begin
                    evicted     = 1'b1;
                    evicted_key = victim_key;
                end
            end
        end
        recent_next = way;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            recent_reg <= '0;
            count_reg  <= '0;
        end else if (proc) begin
            fill_reg   <= fill_next;
            recent_reg <= recent_next;
            count_reg  <= count_next;
        end
    end

    // Result register.
    logic [M_TDATA_W-1:0] out_data_next;

    always_comb begin
        out_data_next                            = '0;
        out_data_next[M_HIT_BIT]                 = hit;
        out_data_next[M_WAY_LSB +: WAY_OUT_W]    = WAY_OUT_W'(way);
        out_data_next[M_EVV_BIT]                 = evicted;
        out_data_next[M_EVK_LSB +: KEY_W]        = evicted_key;
        out_data_next[M_TOTAL_LSB +: COUNT_W]    = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (proc) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_tdata <= out_data_next;
        end
    end

endmodule

>>> rtl/mch_tag_store.sv
`timescale 1ns / 1ps

module mch_tag_store #(
    parameter int WAYS = mch_pkg::WAYS_DEFAULT,
    parameter int IW   = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [mch_pkg::KEY_W-1:0] lookup_key,
    input  logic                      flush,
    input  logic                      upd_en,
    input  logic                      wr_en,
    input  logic [IW-1:0]             wr_way,
    input  logic [IW-1:0]             victim_way,
    output logic                      hit,
    output logic [IW-1:0]             hit_way,
    output logic                      victim_valid,
    output logic [mch_pkg::KEY_W-1:0] victim_key
);
    import mch_pkg::*;

    logic [KEY_W-1:0] key_reg [WAYS];
    logic [WAYS-1:0]  valid_reg;
    logic [WAYS-1:0]  valid_next;
    logic [WAYS-1:0]  valid_eff;

    // A restart request sees an empty cache.
    assign valid_eff = flush ? '0 : valid_reg;

    // Parallel compare against every valid way, lowest index wins.
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (valid_eff[i] && key_reg[i] == lookup_key) begin
                hit     = 1'b1;
                hit_way = IW'(i);
            end
        end
    end

    // Victim read for a replacement.
    assign victim_valid = valid_eff[victim_way];
    assign victim_key   = key_reg[victim_way];

    // Valid bits: cleared by restart, set by a fill or replacement.
    always_comb begin
        valid_next = valid_reg;
        if (upd_en) begin
            valid_next = valid_eff;
            for (int i = 0; i < WAYS; i++) begin
                if (wr_en && wr_way == IW'(i)) begin
                    valid_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Key storage needs no reset; only valid entries are ever read out.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < WAYS; i++) begin
            if (upd_en && wr_en && wr_way == IW'(i)) begin
                key_reg[i] <= lookup_key;
            end
        end
    end

endmodule

>>> rtl/mch_checker.sv
`timescale 1ns / 1ps

module mch_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mch_pkg::M_TDATA_W-1:0] m_tdata
);
    import mch_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The result channel is empty after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A hit never evicts a key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_HIT_BIT] && m_tdata[M_EVV_BIT]))
        else $error("hit reported with eviction");

    // Without an eviction the evicted key reads as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[M_EVV_BIT] |-> m_tdata[M_EVK_LSB +: KEY_W] == '0)
        else $error("evicted key nonzero without eviction");

    // A hit always leaves a nonzero hit total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_HIT_BIT] |-> m_tdata[M_TOTAL_LSB +: COUNT_W] != '0)
        else $error("hit reported with zero hit total");

endmodule

bind mru_cache_hit_counter mch_checker u_mch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/mru_cache_hit_counter_test.sv
`timescale 1ns / 1ps

module mru_cache_hit_counter_test;
    import mch_pkg::*;

    localparam int WAYS        = WAYS_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int POOL_MAX    = 24;

    // One predicted result item.
    typedef struct {
        bit                 hit;
        logic [WAY_OUT_W-1:0] way;
        bit                 evicted;
        logic [KEY_W-1:0]   victim;
        logic [COUNT_W-1:0] total;
    } lookup_t;

    // Cache predictor plus the queue of lookups still waiting for their result.
    class CacheScoreboard;
        logic [KEY_W-1:0]   tag [WAYS];
        bit                 live [WAYS];
        int unsigned        fill;
        int unsigned        mru;
        logic [COUNT_W-1:0] hits;
        logic [CAP_W-1:0]   capacity;
        lookup_t            awaiting [$];
        int                 errors;
        int                 requests;
        int                 hit_count;
        int                 evict_count;

        function new();
            errors = 0;
            requests = 0;
            hit_count = 0;
            evict_count = 0;
            capacity = CAPACITY_RESET;
            foreach (tag[i]) tag[i] = '0;
            clear();
        endfunction

        function void clear();
            foreach (live[i]) live[i] = 1'b0;
            fill = 0;
            mru = 0;
            hits = '0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
        endfunction

        function int pending();
            return awaiting.size();
        endfunction

        // Work out the result of one accepted lookup request.
        function void note_request(logic [KEY_W-1:0] key, bit restart);
            lookup_t     res;
            int unsigned limit;
            int unsigned way;
            res.hit = 1'b0;
            res.evicted = 1'b0;
            res.victim = '0;
            way = 0;
            if (restart) clear();
            for (int i = 0; i < WAYS; i++) begin
                if (!res.hit && live[i] && tag[i] == key) begin
                    res.hit = 1'b1;
                    way = i;
                end
            end
            if (res.hit) begin
                if (hits != COUNT_MAX) hits = hits + 1'b1;
                hit_count++;
            end else begin
                // A zero capacity behaves as one, anything past the way count as all ways.
                limit = (capacity == 0) ? 1 : ((capacity > WAYS) ? WAYS : capacity);
                if (fill < limit) begin
                    way = fill;
                    fill++;
                end else begin
                    // Full, possibly because capacity dropped below the fill level.
                    way = mru % WAYS;
                    if (live[way]) begin
                        res.evicted = 1'b1;
                        res.victim = tag[way];
                        evict_count++;
                    end
                end
                tag[way] = key;
                live[way] = 1'b1;
            end
            mru = way;
            res.way = way[WAY_OUT_W-1:0];
            res.total = hits;
            awaiting.push_back(res);
            requests++;
        endfunction

        task report(string msg);
            if (errors < 40) $display("mismatch: %s", msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(logic [M_TDATA_W-1:0] data);
            lookup_t want;
            lookup_t got;
            if (awaiting.size() == 0) begin
                report($sformatf("result %h arrived with no lookup outstanding", data));
            end else begin
                want = awaiting.pop_front();
                got.hit = data[M_HIT_BIT];
                got.way = data[M_WAY_LSB +: WAY_OUT_W];
                got.evicted = data[M_EVV_BIT];
                got.victim = data[M_EVK_LSB +: KEY_W];
                got.total = data[M_TOTAL_LSB +: COUNT_W];
                if (got.hit !== want.hit)
                    report($sformatf("hit got %b expected %b", got.hit, want.hit));
                if (got.way !== want.way)
                    report($sformatf("way_used got %0d expected %0d", got.way, want.way));
                if (got.evicted !== want.evicted)
                    report($sformatf("evicted_valid got %b expected %b",
                                     got.evicted, want.evicted));
                if (got.victim !== want.victim)
                    report($sformatf("evicted_key got %h expected %h",
                                     got.victim, want.victim));
                if (got.total !== want.total)
                    report($sformatf("hit_total got %0d expected %0d", got.total, want.total));
            end
        endtask

        task final_check();
            while (awaiting.size() != 0) begin
                void'(awaiting.pop_front());
                report("lookup result never arrived");
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CAP_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: access_key[31:0], restart[32], zero[39:33]
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: hit[0], way_used[4:1], evicted_valid[5], evicted_key[37:6],
    //          hit_total[69:38], zero[71:70]
    logic [M_TDATA_W-1:0]  m_tdata;

    CacheScoreboard sb;
    int send_idle_pct = 7;
    int recv_idle_pct = 77;
    int cap_writes = 0;
    int stall_cycles = 0;

    mru_cache_hit_counter #(.WAYS(WAYS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: random back-pressure and checking of every accepted result.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // End the run when no request, result or register write moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Present one lookup request, with random idle cycles ahead of it.
    task automatic send_request(logic [KEY_W-1:0] key, bit restart);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_KEY_LSB +: KEY_W] = key;
        word[S_RESTART_BIT] = restart;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(key, restart);
    endtask

    // Stop sending and wait until every outstanding lookup has returned.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_capacity(value);
        cap_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Random lookups drawn mostly from a small key pool so that hits and
    // replacements both occur; the rest are arbitrary keys.
    task automatic run_phase(int pool_n, bit pause_midway);
        logic [KEY_W-1:0] pool [POOL_MAX];
        logic [KEY_W-1:0] key;
        bit               restart;
        foreach (pool[i]) pool[i] = $urandom;
        if ($urandom_range(1)) pool[0] = '0;
        if ($urandom_range(1)) pool[pool_n-1] = '1;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 88) key = pool[$urandom_range(pool_n - 1)];
            else key = $urandom;
            restart = ($urandom_range(99) < 3);
            if (pause_midway && i == PHASE_ITEMS / 2) drain_results();
            send_request(key, restart);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps [PHASES];
        int               eff;
        caps = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd9, 5'd1, 5'd16, 5'd5};
        sb = new();
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme keys, hits, restart, replacement at the smallest
        // capacity, capacity lowered below the fill level and raised again.
        // The saturating counter limit is out of reach in a run of this length.
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(32'hA5A5_A5A5, 1'b1);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'hA5A5_A5A5, 1'b0);
        write_capacity(5'd2);
        send_request(32'h5A5A_5A5A, 1'b0);
        write_capacity(5'd0);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0000, 1'b0);
        send_request(32'h0000_0002, 1'b0);
        write_capacity(5'd31);
        send_request(32'h0000_0003, 1'b0);
        send_request(32'h5555_5555, 1'b0);
        send_request(32'hAAAA_AAAA, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b1);
        send_request(32'hAAAA_AAAA, 1'b0);

        // Random phases; the cache is not emptied across capacity changes.
        for (int p = 0; p < PHASES; p++) begin
            write_capacity(caps[p]);
            if (p < 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 77;
            end else if (p < 6) begin
                send_idle_pct = 77;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            eff = (caps[p] == 0) ? 1 : ((caps[p] > WAYS) ? WAYS : caps[p]);
            run_phase(eff + $urandom_range(0, 5), p == 2 || p == 6);
        end

        drain_results();
        repeat (10) @(posedge aclk);
        sb.final_check();
        $display("Ran %0d lookups across %0d capacity writes, from 0 up to 31.",
                 sb.requests, cap_writes);
        $display("Predicted %0d hits and %0d evictions; %0d mismatches.",
                 sb.hit_count, sb.evict_count, sb.errors);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
